### rtl/core/icrp_pkg.sv
// Shared types and constants for the int8 convolution and requantisation engine.
`default_nettype none

package icrp_pkg;

  // Store sizes; all are powers of two so that indexes wrap naturally.
  localparam int unsigned ACT_WORDS    = 4096;
  localparam int unsigned WEIGHT_WORDS = 4096;
  localparam int unsigned MAX_MAPS     = 64;
  localparam int unsigned ACT_AW       = $clog2(ACT_WORDS);
  localparam int unsigned WGT_AW       = $clog2(WEIGHT_WORDS);
  localparam int unsigned MAP_AW       = $clog2(MAX_MAPS);

  // Command queue and result buffer depths.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned RESQ_DEPTH = 2;
  localparam int unsigned RESQ_PW    = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  // Accumulator, requantisation product and saturation bounds.
  localparam int unsigned ACC_W   = 34;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned PPROD_W = ACC_W + HALF_W + 1;
  localparam int unsigned FULL_W  = ACC_W + 33;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned Q_W     = FULL_W - FRAC_W;
  localparam logic signed [Q_W:0] SAT_HI = (Q_W + 1)'(127);
  localparam logic signed [Q_W:0] SAT_LO = -(Q_W + 1)'(128);

  // Input modes as they arrive on the port.
  localparam logic [1:0] MODE_LOAD_ACT  = 2'd0;
  localparam logic [1:0] MODE_LOAD_WGT  = 2'd1;
  localparam logic [1:0] MODE_LOAD_BIAS = 2'd2;
  localparam logic [1:0] MODE_COMPUTE   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IN_CHANNELS   = 3'd2;
  localparam logic [2:0] REG_IN_WIDTH      = 3'd3;
  localparam logic [2:0] REG_IN_HEIGHT     = 3'd4;
  localparam logic [2:0] REG_OUT_MAPS      = 3'd5;
  localparam logic [2:0] REG_REQUANT_SCALE = 3'd6;
  localparam logic [2:0] REG_OUT_ZERO_PT   = 3'd7;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD_ACT,
    CMD_LOAD_WGT,
    CMD_LOAD_BIAS,
    CMD_COMPUTE,
    CMD_RANGE_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [11:0] address;
    logic [31:0] value;
    logic [5:0]  out_map;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
  } cmd_t;

  typedef struct packed {
    logic [3:0]        kernel_width;
    logic [3:0]        kernel_height;
    logic [6:0]        in_channels;
    logic [6:0]        in_width;
    logic [6:0]        in_height;
    logic [6:0]        out_maps;
    logic [31:0]       requant_scale;
    logic signed [7:0] out_zero_point;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       status;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SETUP2,
    ST_SETUP3,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

### rtl/core/icrp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module icrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/icrp_front.sv
// Front end: configuration registers and classification of incoming transactions.
`default_nettype none

module icrp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic [1:0]    mode_i,
  input  wire logic [11:0]   address_i,
  input  wire logic [31:0]   value_i,
  input  wire logic [5:0]    out_map_i,
  input  wire logic [5:0]    out_row_i,
  input  wire logic [5:0]    out_col_i,
  output icrp_pkg::cfg_t     cfg_o,
  output icrp_pkg::cmd_t     cmd_o
);

  import icrp_pkg::*;

  cfg_t cfg_q;
  logic row_bad;
  logic col_bad;
  logic map_bad;

  // Configuration registers, written one at a time by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_width   <= 4'd3;
      cfg_q.kernel_height  <= 4'd3;
      cfg_q.in_channels    <= 7'd1;
      cfg_q.in_width       <= 7'd28;
      cfg_q.in_height      <= 7'd28;
      cfg_q.out_maps       <= 7'd1;
      cfg_q.requant_scale  <= 32'd0;
      cfg_q.out_zero_point <= 8'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KERNEL_WIDTH:  cfg_q.kernel_width   <= cfg_data_i[3:0];
        REG_KERNEL_HEIGHT: cfg_q.kernel_height  <= cfg_data_i[3:0];
        REG_IN_CHANNELS:   cfg_q.in_channels    <= cfg_data_i[6:0];
        REG_IN_WIDTH:      cfg_q.in_width       <= cfg_data_i[6:0];
        REG_IN_HEIGHT:     cfg_q.in_height      <= cfg_data_i[6:0];
        REG_OUT_MAPS:      cfg_q.out_maps       <= cfg_data_i[6:0];
        REG_REQUANT_SCALE: cfg_q.requant_scale  <= cfg_data_i;
        REG_OUT_ZERO_PT:   cfg_q.out_zero_point <= $signed(cfg_data_i[7:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // Range check of the requested output position.
  assign map_bad = ({1'b0, out_map_i} >= cfg_q.out_maps);
  assign row_bad = ({2'b00, out_row_i} + {4'd0, cfg_q.kernel_height}) >
                   {1'b0, cfg_q.in_height};
  assign col_bad = ({2'b00, out_col_i} + {4'd0, cfg_q.kernel_width}) >
                   {1'b0, cfg_q.in_width};

  // Classify the transaction into a command for the back end.
  always_comb begin
    cmd_o.address = address_i;
    cmd_o.value   = value_i;
    cmd_o.out_map = out_map_i;
    cmd_o.out_row = out_row_i;
    cmd_o.out_col = out_col_i;
    case (mode_i)
      MODE_LOAD_ACT:  cmd_o.kind = CMD_LOAD_ACT;
      MODE_LOAD_WGT:  cmd_o.kind = CMD_LOAD_WGT;
      MODE_LOAD_BIAS: cmd_o.kind = CMD_LOAD_BIAS;
      MODE_COMPUTE:   cmd_o.kind = (map_bad || row_bad || col_bad) ? CMD_RANGE_ERR
                                                                   : CMD_COMPUTE;
      default:        cmd_o.kind = CMD_LOAD_ACT;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/icrp_cmdq.sv
// Short command queue between the front end and the back end.
`default_nettype none

module icrp_cmdq (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  icrp_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output icrp_pkg::cmd_t  cmd_o,
  output logic            empty_o
);

  import icrp_pkg::*;

  cmd_t                entry_q [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0]  wr_ptr_q;
  logic [CMDQ_PW-1:0]  rd_ptr_q;
  logic [CMDQ_CW-1:0]  count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/icrp_back.sv
// Back end: store writes, the multiply-accumulate sequencer, requantisation and results.
`default_nettype none

module icrp_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  icrp_pkg::cfg_t  cfg_i,
  input  icrp_pkg::cmd_t  cmd_i,
  input  wire logic       cmd_empty_i,
  output logic            cmd_pop_o,
  output logic [7:0]      pixel_o,
  output logic            status_o,
  output logic            empty_o,
  input  wire logic       pop_i
);

  import icrp_pkg::*;

  back_state_e state_q, state_d;

  // Current compute command.
  logic [5:0]  map_q;
  logic [5:0]  row_q;
  logic [5:0]  col_q;
  logic        err_q;

  // Loop counters and store addresses.
  logic [3:0]        s_q;
  logic [3:0]        r_q;
  logic [6:0]        c_q;
  logic [ACT_AW-1:0] a_chan_q;
  logic [ACT_AW-1:0] a_row_q;
  logic [ACT_AW-1:0] a_q;
  logic [ACT_AW-1:0] hw_q;
  logic [WGT_AW-1:0] w_q;

  // Datapath registers.
  logic                      rd_v_q;
  logic                      prod_v_q;
  logic signed [15:0]        prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PPROD_W-1:0] plo_q;
  logic signed [PPROD_W-1:0] phi_q;
  logic signed [Q_W-1:0]     q_q;

  // Store ports.
  logic [7:0]  act_rdata;
  logic [7:0]  wgt_rdata;
  logic [31:0] bias_rdata;
  logic        load_act;
  logic        load_wgt;
  logic        load_bias;
  logic        mac_issue;
  logic        bias_re;

  // Control decode.
  logic        s_last;
  logic        r_last;
  logic        c_last;
  logic        empty_sum;
  logic        start_cmd;

  // Requantisation arithmetic.
  logic [HALF_W-1:0]         scale_half;
  logic signed [PPROD_W-1:0] mul_res;
  logic signed [FULL_W-1:0]  full_sum;
  logic signed [Q_W:0]       relu_zp;
  logic [7:0]                pixel_sat;
  res_t                      res_new;

  // Result buffer.
  res_t                res_q [RESQ_DEPTH];
  logic [RESQ_PW-1:0]  res_wr_q;
  logic [RESQ_PW-1:0]  res_rd_q;
  logic [RESQ_CW-1:0]  res_cnt_q;
  logic                res_push;
  logic                res_pop;
  logic                res_room;

  // Loads are carried out straight from the queue head.
  assign start_cmd = (state_q == ST_IDLE) && !cmd_empty_i;
  assign cmd_pop_o = start_cmd;
  assign load_act  = start_cmd && (cmd_i.kind == CMD_LOAD_ACT);
  assign load_wgt  = start_cmd && (cmd_i.kind == CMD_LOAD_WGT);
  assign load_bias = start_cmd && (cmd_i.kind == CMD_LOAD_BIAS);
  assign mac_issue = (state_q == ST_RUN);
  assign bias_re   = (state_q == ST_SETUP);

  icrp_ram #(.WIDTH(8), .DEPTH(ACT_WORDS)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (load_act),
    .waddr_i (cmd_i.address[ACT_AW-1:0]),
    .wdata_i (cmd_i.value[7:0]),
    .re_i    (mac_issue),
    .raddr_i (a_q),
    .rdata_o (act_rdata)
  );

  icrp_ram #(.WIDTH(8), .DEPTH(WEIGHT_WORDS)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (load_wgt),
    .waddr_i (cmd_i.address[WGT_AW-1:0]),
    .wdata_i (cmd_i.value[7:0]),
    .re_i    (mac_issue),
    .raddr_i (w_q),
    .rdata_o (wgt_rdata)
  );

  icrp_ram #(.WIDTH(32), .DEPTH(MAX_MAPS)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (load_bias),
    .waddr_i (cmd_i.address[MAP_AW-1:0]),
    .wdata_i (cmd_i.value),
    .re_i    (bias_re),
    .raddr_i (map_q[MAP_AW-1:0]),
    .rdata_o (bias_rdata)
  );

  // Loop end conditions.
  assign s_last    = (s_q == cfg_i.kernel_width - 4'd1);
  assign r_last    = (r_q == cfg_i.kernel_height - 4'd1);
  assign c_last    = (c_q == cfg_i.in_channels - 7'd1);
  assign empty_sum = (cfg_i.kernel_width == '0) || (cfg_i.kernel_height == '0) ||
                     (cfg_i.in_channels == '0);

  // Shared multiplier for the two halves of the scale.
  assign scale_half = (state_q == ST_MUL_LO) ? cfg_i.requant_scale[HALF_W-1:0]
                                             : cfg_i.requant_scale[31:HALF_W];
  assign mul_res    = PPROD_W'($signed(acc_q) * $signed({1'b0, scale_half}));
  assign full_sum   = (FULL_W'(phi_q) <<< HALF_W) + FULL_W'(plo_q);

  // ReLU, zero point and saturation.
  always_comb begin
    if (q_q[Q_W-1] || (q_q == '0)) begin
      relu_zp = (Q_W + 1)'(cfg_i.out_zero_point);
    end else begin
      relu_zp = (Q_W + 1)'(q_q) + (Q_W + 1)'(cfg_i.out_zero_point);
    end
    if (relu_zp > SAT_HI) begin
      pixel_sat = 8'sd127;
    end else if (relu_zp < SAT_LO) begin
      pixel_sat = 8'h80;
    end else begin
      pixel_sat = relu_zp[7:0];
    end
    res_new.pixel  = err_q ? 8'd0 : pixel_sat;
    res_new.status = err_q ? STATUS_RANGE : STATUS_OK;
  end

  assign res_room = (res_cnt_q != RESQ_CW'(RESQ_DEPTH));
  assign res_push = (state_q == ST_OUT) && res_room;
  assign res_pop  = pop_i && !empty_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_cmd && cmd_i.kind == CMD_COMPUTE) begin
          state_d = ST_SETUP;
        end else if (start_cmd && cmd_i.kind == CMD_RANGE_ERR) begin
          state_d = ST_OUT;
        end
      end
      ST_SETUP:  state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_SETUP3;
      ST_SETUP3: state_d = empty_sum ? ST_BIAS : ST_RUN;
      ST_RUN: begin
        if (s_last && r_last && c_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          state_d = ST_BIAS;
        end
      end
      ST_BIAS:   state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_OUT;
      ST_OUT: begin
        if (res_room) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read-data and product valid flags of the multiply-accumulate pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= mac_issue;
      prod_v_q <= rd_v_q;
    end
  end

  // Command capture, address setup, loop stepping and arithmetic.
  always_ff @(posedge clk_i) begin
    if (start_cmd) begin
      map_q <= cmd_i.out_map;
      row_q <= cmd_i.out_row;
      col_q <= cmd_i.out_col;
      err_q <= (cmd_i.kind == CMD_RANGE_ERR);
    end
    if (rd_v_q) begin
      prod_q <= 16'($signed(act_rdata) * $signed(wgt_rdata));
    end
    case (state_q)
      ST_SETUP: begin
        a_row_q <= ACT_AW'(ACT_AW'(row_q) * ACT_AW'(cfg_i.in_width)) + ACT_AW'(col_q);
        hw_q    <= ACT_AW'(ACT_AW'(cfg_i.in_height) * ACT_AW'(cfg_i.in_width));
        w_q     <= WGT_AW'(WGT_AW'(map_q) * WGT_AW'(cfg_i.in_channels));
        acc_q   <= '0;
      end
      ST_SETUP2: begin
        w_q <= WGT_AW'(w_q * WGT_AW'(cfg_i.kernel_height));
      end
      ST_SETUP3: begin
        w_q      <= WGT_AW'(w_q * WGT_AW'(cfg_i.kernel_width));
        a_chan_q <= a_row_q;
        a_q      <= a_row_q;
        s_q      <= '0;
        r_q      <= '0;
        c_q      <= '0;
      end
      ST_RUN: begin
        w_q <= w_q + 1'b1;
        if (!s_last) begin
          s_q <= s_q + 1'b1;
          a_q <= a_q + 1'b1;
        end else if (!r_last) begin
          s_q     <= '0;
          r_q     <= r_q + 1'b1;
          a_row_q <= a_row_q + ACT_AW'(cfg_i.in_width);
          a_q     <= a_row_q + ACT_AW'(cfg_i.in_width);
        end else begin
          s_q      <= '0;
          r_q      <= '0;
          c_q      <= c_q + 1'b1;
          a_chan_q <= a_chan_q + hw_q;
          a_row_q  <= a_chan_q + hw_q;
          a_q      <= a_chan_q + hw_q;
        end
      end
      ST_BIAS:   acc_q <= acc_q + ACC_W'($signed(bias_rdata));
      ST_MUL_LO: plo_q <= mul_res;
      ST_MUL_HI: phi_q <= mul_res;
      ST_SUM:    q_q   <= full_sum[FULL_W-1:FRAC_W];
      default: ;
    endcase
    if (prod_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Result buffer storage.
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_new;
    end
  end

  // Result buffer pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= (res_wr_q == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= (res_rd_q == RESQ_PW'(RESQ_DEPTH - 1)) ? '0 : res_rd_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  assign empty_o  = (res_cnt_q == '0);
  assign pixel_o  = res_q[res_rd_q].pixel;
  assign status_o = res_q[res_rd_q].status;

  // The store reads are issued only while the loop runs, so no read is in flight on entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (!rd_v_q && !prod_v_q))
    else $error("multiply-accumulate pipeline busy at the start of a pixel");

  // The channel counter stays inside the configured depth while the loop runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (c_q < cfg_i.in_channels))
    else $error("channel counter beyond the configured depth");

  // A new command is only taken once the previous one has fully finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE))
    else $error("command taken while the back end is busy");

  // The result buffer never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_cnt_q < RESQ_CW'(RESQ_DEPTH) || res_pop))
    else $error("result buffer overflow");

endmodule

`default_nettype wire

### rtl/core/int8_conv_requant_pixel_top.sv
// Top level of the int8 convolution engine with requantisation, one output pixel per transaction.
//
// Usage: configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// engine is idle. Input transactions are pushed with push_i while full_o is low; mode selects
// an activation, weight or bias load, or the computation of one output pixel. Loads give no
// result. Each compute transaction gives one result (pixel_o, status_o) that is shown while
// empty_o is low and taken with pop_i.
// Operation: a load is written to its store as it leaves the queue, and the back end stays idle.
// A pixel takes one multiply-accumulate per kernel element, paced by the single read port of
// the activation and weight stores, plus address setup, bias add, a two-pass requantisation
// multiply and the result write. A position out of range gives status 1.
// A two-entry command queue lets loads and pixels queue while the back end works, and a
// two-entry result buffer lets the back end finish a pixel while the receiver stalls; once
// that buffer is full the back end waits and the command queue fills, raising full_o.
// Reset sets the registers to their documented defaults and empties both queues; the stores
// are not cleared and must be written before use.
`default_nettype none

module int8_conv_requant_pixel_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [11:0] address_i,
  input  wire logic [31:0] value_i,
  input  wire logic [5:0]  out_map_i,
  input  wire logic [5:0]  out_row_i,
  input  wire logic [5:0]  out_col_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [7:0]       pixel_o,
  output logic             status_o
);

  import icrp_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  // Configuration and classification.
  icrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mode_i     (mode_i),
    .address_i  (address_i),
    .value_i    (value_i),
    .out_map_i  (out_map_i),
    .out_row_i  (out_row_i),
    .out_col_i  (out_col_i),
    .cfg_o      (cfg),
    .cmd_o      (cmd_in)
  );

  // Command queue between the two halves.
  icrp_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .cmd_i   (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  // Execution and result delivery.
  icrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pixel_o     (pixel_o),
    .status_o    (status_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

endmodule

`default_nettype wire
